// ===== design/idll_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idll_pkg
// types and constants shared by the linked list core and its link memory
// ----------------------------------------------------------------------------
package idll_pkg;

    localparam int MaxNodes = 64;
    localparam int IdW      = 7;
    localparam int CntW     = $clog2(MaxNodes);

    typedef logic [IdW-1:0]  t_id;
    typedef logic [CntW-1:0] t_cnt;

    localparam t_id NullId  = '0;
    localparam t_id FirstId = t_id'(1);
    localparam t_id MaxId   = t_id'(MaxNodes);

    typedef enum logic [1:0] {
        CMD_INS_LEFT  = 2'd0,
        CMD_INS_RIGHT = 2'd1,
        CMD_REMOVE    = 2'd2,
        CMD_READOUT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_ABSENT  = 2'd2,
        STS_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FIX,
        S_WALK,
        S_OUT
    } t_state;

    // next link entry carries the presence flag of its own id
    typedef struct packed {
        logic pres;
        t_id  link;
    } t_nx_word;

    typedef struct packed {
        logic     nx_we;
        t_id      nx_addr;
        t_nx_word nx_word;
        logic     pv_we;
        t_id      pv_addr;
        t_id      pv_data;
    } t_link_wr;

    typedef struct packed {
        t_nx_word nx;
        t_id      pv;
    } t_link_rd;

endpackage

// ===== design/indexed_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list
// ordered list of node ids kept in next and previous link memories by id
// ----------------------------------------------------------------------------
// One command beat in, its result beats out; a new command is taken only once
// the last result beat of the previous one has gone. Insert and remove read the
// links of the reference id, then write in an execute state and, for a
// successful insert or a non-head remove, in a fix state, as each link memory
// has one write port; then comes the output beat. Readout does one registered
// link read and one output beat per listed id, up to 64 ids. After reset the
// list holds id 1 alone; no clearing pass is needed.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list import idll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // ref_id[6:0], zero [7]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // node_id[6:0], status[8:7], zero [15:9]
    output logic        m_axis_tlast,   // is_last
    output logic        m_axis_tuser    // list_empty
);

    t_state   r_state, n_state;
    t_cmd     r_cmd, n_cmd;
    t_id      r_ref, n_ref;
    t_id      r_head, n_head;
    t_id      r_free, n_free;
    t_id      r_cur, n_cur;
    t_cnt     r_cnt, n_cnt;
    t_id      r_nb, n_nb;
    t_id      r_nx, n_nx;
    logic     r_o_valid, n_o_valid;
    t_id      r_o_node, n_o_node;
    t_status  r_o_status, n_o_status;
    logic     r_o_last, n_o_last;
    logic     r_o_empty, n_o_empty;

    t_id      rd_addr;
    t_link_wr wr;
    t_link_rd rd;
    t_id      in_ref;
    logic     in_ok;
    logic     ref_ok;
    logic     pres;
    logic     full;
    logic     is_ins;

    idll_link_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd      (rd)
    );

    assign in_ref = s_axis_tdata[IdW-1:0];
    assign in_ok  = (in_ref != NullId) && (in_ref <= MaxId);
    assign ref_ok = (r_ref != NullId) && (r_ref <= MaxId);
    assign pres   = ref_ok && rd.nx.pres;
    assign full   = (r_free > MaxId);
    assign is_ins = (r_cmd == CMD_INS_LEFT) || (r_cmd == CMD_INS_RIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= FirstId;
            r_free    <= t_id'(2);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_free    <= n_free;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_ref      <= n_ref;
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_nb       <= n_nb;
        r_nx       <= n_nx;
        r_o_node   <= n_o_node;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
        r_o_empty  <= n_o_empty;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_ref      = r_ref;
        n_head     = r_head;
        n_free     = r_free;
        n_cur      = r_cur;
        n_cnt      = r_cnt;
        n_nb       = r_nb;
        n_nx       = r_nx;
        n_o_valid  = r_o_valid;
        n_o_node   = r_o_node;
        n_o_status = r_o_status;
        n_o_last   = r_o_last;
        n_o_empty  = r_o_empty;
        rd_addr    = r_cur;
        wr         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_cmd = t_cmd'(s_axis_tuser);
                    n_ref = in_ref;
                    if (t_cmd'(s_axis_tuser) == CMD_READOUT) begin
                        if (r_head == NullId) begin
                            n_o_valid  = 1'b1;
                            n_o_node   = NullId;
                            n_o_status = STS_OK;
                            n_o_last   = 1'b1;
                            n_o_empty  = 1'b1;
                            n_state    = S_OUT;
                        end else begin
                            rd_addr = r_head;
                            n_cur   = r_head;
                            n_cnt   = '0;
                            n_state = S_WALK;
                        end
                    end else begin
                        rd_addr = in_ok ? in_ref : NullId;
                        n_state = S_EXEC;
                    end
                end
            end

            S_EXEC: begin
                n_o_last  = 1'b1;
                n_o_empty = 1'b0;
                if (is_ins) begin
                    if (full || !pres) begin
                        n_o_valid  = 1'b1;
                        n_o_node   = NullId;
                        n_o_status = full ? STS_FULL : STS_ABSENT;
                        n_state    = S_OUT;
                    end else begin
                        wr.nx_we        = 1'b1;
                        wr.nx_addr      = r_free;
                        wr.nx_word.pres = 1'b1;
                        wr.pv_we        = 1'b1;
                        wr.pv_addr      = r_free;
                        if (r_cmd == CMD_INS_LEFT) begin
                            n_nb            = rd.pv;
                            wr.pv_data      = rd.pv;
                            wr.nx_word.link = r_ref;
                        end else begin
                            n_nb            = rd.nx.link;
                            wr.pv_data      = r_ref;
                            wr.nx_word.link = rd.nx.link;
                        end
                        n_state = S_FIX;
                    end
                end else if (!pres) begin
                    n_o_valid  = 1'b1;
                    n_o_node   = r_ref;
                    n_o_status = STS_IGNORED;
                    n_state    = S_OUT;
                end else begin
                    wr.nx_we        = 1'b1;
                    wr.nx_addr      = r_ref;
                    wr.nx_word.pres = 1'b0;
                    wr.nx_word.link = rd.nx.link;
                    wr.pv_we        = (rd.nx.link != NullId);
                    wr.pv_addr      = rd.nx.link;
                    wr.pv_data      = rd.pv;
                    n_nb            = rd.pv;
                    n_nx            = rd.nx.link;
                    if (rd.pv == NullId) begin
                        n_head     = rd.nx.link;
                        n_o_valid  = 1'b1;
                        n_o_node   = r_ref;
                        n_o_status = STS_OK;
                        n_state    = S_OUT;
                    end else begin
                        n_state = S_FIX;
                    end
                end
            end

            S_FIX: begin
                n_o_valid  = 1'b1;
                n_o_status = STS_OK;
                n_o_last   = 1'b1;
                n_o_empty  = 1'b0;
                n_state    = S_OUT;
                wr.nx_word.pres = 1'b1;
                if (r_cmd == CMD_INS_LEFT) begin
                    wr.nx_we        = (r_nb != NullId);
                    wr.nx_addr      = r_nb;
                    wr.nx_word.link = r_free;
                    wr.pv_we        = 1'b1;
                    wr.pv_addr      = r_ref;
                    wr.pv_data      = r_free;
                    if (r_head == r_ref) begin
                        n_head = r_free;
                    end
                    n_free   = r_free + t_id'(1);
                    n_o_node = r_free;
                end else if (r_cmd == CMD_INS_RIGHT) begin
                    wr.nx_we        = 1'b1;
                    wr.nx_addr      = r_ref;
                    wr.nx_word.link = r_free;
                    wr.pv_we        = (r_nb != NullId);
                    wr.pv_addr      = r_nb;
                    wr.pv_data      = r_free;
                    n_free          = r_free + t_id'(1);
                    n_o_node        = r_free;
                end else begin
                    wr.nx_we        = 1'b1;
                    wr.nx_addr      = r_nb;
                    wr.nx_word.link = r_nx;
                    n_o_node        = r_ref;
                end
            end

            S_WALK: begin
                n_o_valid  = 1'b1;
                n_o_node   = r_cur;
                n_o_status = STS_OK;
                n_o_empty  = 1'b0;
                n_o_last   = (rd.nx.link == NullId) || (r_cnt == t_cnt'(MaxNodes - 1));
                n_cur      = rd.nx.link;
                n_cnt      = r_cnt + t_cnt'(1);
                n_state    = S_OUT;
            end

            S_OUT: begin
                if (m_axis_tready) begin
                    n_o_valid = 1'b0;
                    if (r_o_last) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_addr = r_cur;
                        n_state = S_WALK;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {7'd0, r_o_status, r_o_node};
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tuser  = r_o_empty;

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("command taken while a result beat is pending");

    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free >= t_id'(2)) && (r_free <= MaxId + t_id'(1)))
        else $error("next free id out of range");

    a_free_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) && is_ins |=> r_free == $past(r_free) + t_id'(1))
        else $error("insert did not advance the free id");

    a_walk_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_cur != NullId) && (r_cur <= MaxId))
        else $error("readout walked onto a null id");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (r_head == NullId))
        else $error("empty flag on a beat that is not a lone empty readout");

endmodule

// ===== design/idll_link_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idll_link_mem
// next and previous link memories, one write and one registered read each
// ----------------------------------------------------------------------------
module idll_link_mem import idll_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_id      i_rd_addr,
    input  t_link_wr i_wr,
    output t_link_rd o_rd
);

    t_nx_word         r_nx_mem [0:MaxNodes];
    t_id              r_pv_mem [0:MaxNodes];
    logic [MaxNodes:0] r_nx_vld;
    logic [MaxNodes:0] r_pv_vld;
    t_nx_word         r_nx_q;
    t_id              r_pv_q;
    logic             r_nx_v;
    logic             r_pv_v;
    logic             r_first;

    always_ff @(posedge i_clk) begin
        if (i_wr.nx_we) begin
            r_nx_mem[i_wr.nx_addr] <= i_wr.nx_word;
        end
        if (i_wr.pv_we) begin
            r_pv_mem[i_wr.pv_addr] <= i_wr.pv_data;
        end
        r_nx_q <= r_nx_mem[i_rd_addr];
        r_pv_q <= r_pv_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx_vld <= '0;
            r_pv_vld <= '0;
            r_nx_v   <= 1'b0;
            r_pv_v   <= 1'b0;
            r_first  <= 1'b0;
        end else begin
            if (i_wr.nx_we) begin
                r_nx_vld[i_wr.nx_addr] <= 1'b1;
            end
            if (i_wr.pv_we) begin
                r_pv_vld[i_wr.pv_addr] <= 1'b1;
            end
            r_nx_v  <= r_nx_vld[i_rd_addr];
            r_pv_v  <= r_pv_vld[i_rd_addr];
            r_first <= (i_rd_addr == FirstId);
        end
    end

    // untouched entries read as reset contents: null links, only id 1 present
    assign o_rd.nx = r_nx_v ? r_nx_q : t_nx_word'{pres: r_first, link: NullId};
    assign o_rd.pv = r_pv_v ? r_pv_q : NullId;

endmodule

// ===== test/indexed_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_checker
// Watches the command and result streams of the indexed linked list. It keeps
// its own copy of the link tables, works out the result beats of every
// accepted command and compares each result beat, field by field, with the
// oldest one still due.
// ----------------------------------------------------------------------------
module indexed_list_checker import idll_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [7:0]  i_cmd_data,    // ref_id[6:0], zero [7]
    input  logic [1:0]  i_cmd_user,    // cmd[1:0]
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [15:0] i_res_data,    // node_id[6:0], status[8:7], zero [15:9]
    input  logic        i_res_last,    // is_last
    input  logic        i_res_user,    // list_empty
    output int          o_errors,
    output int          o_outstanding
);

    typedef struct {
        t_id     node;
        t_status st;
        logic    last;
        logic    empty;
    } t_result;

    t_result due_q[$];

    t_id  nxt_tbl [0:MaxNodes];
    t_id  prv_tbl [0:MaxNodes];
    logic live_tbl[0:MaxNodes];
    t_id  head_id;
    t_id  free_id;
    int   errors  = 0;
    int   pending = 0;

    assign o_errors      = errors;
    assign o_outstanding = pending;

    function automatic bit is_live(t_id id);
        return id >= FirstId && id <= MaxId && live_tbl[id];
    endfunction

    function automatic void due(t_id node, t_status st, logic last, logic empty);
        due_q.push_back('{node, st, last, empty});
    endfunction

    function automatic void clear_list();
        for (int i = 0; i <= MaxNodes; i++) begin
            nxt_tbl[i]  = NullId;
            prv_tbl[i]  = NullId;
            live_tbl[i] = 1'b0;
        end
        live_tbl[FirstId] = 1'b1;
        head_id = FirstId;
        free_id = t_id'(2);
        due_q.delete();
    endfunction

    function automatic void apply_cmd(t_cmd cmd, t_id anchor);
        t_id nid;
        t_id nb;
        t_id pv;
        t_id nx;
        t_id cur;
        int  cnt;
        case (cmd)
            CMD_INS_LEFT, CMD_INS_RIGHT: begin
                if (free_id > MaxId) begin
                    due(NullId, STS_FULL, 1'b1, 1'b0);
                end else if (!is_live(anchor)) begin
                    due(NullId, STS_ABSENT, 1'b1, 1'b0);
                end else begin
                    nid = free_id;
                    if (cmd == CMD_INS_LEFT) begin
                        nb = prv_tbl[anchor];
                        prv_tbl[nid] = nb;
                        nxt_tbl[nid] = anchor;
                        if (nb != NullId && nb <= MaxId) nxt_tbl[nb] = nid;
                        prv_tbl[anchor] = nid;
                        if (head_id == anchor) head_id = nid;
                    end else begin
                        nb = nxt_tbl[anchor];
                        prv_tbl[nid] = anchor;
                        nxt_tbl[nid] = nb;
                        if (nb != NullId && nb <= MaxId) prv_tbl[nb] = nid;
                        nxt_tbl[anchor] = nid;
                    end
                    live_tbl[nid] = 1'b1;
                    free_id = nid + t_id'(1);
                    due(nid, STS_OK, 1'b1, 1'b0);
                end
            end
            CMD_REMOVE: begin
                if (!is_live(anchor)) begin
                    due(anchor, STS_IGNORED, 1'b1, 1'b0);
                end else begin
                    pv = prv_tbl[anchor];
                    nx = nxt_tbl[anchor];
                    live_tbl[anchor] = 1'b0;
                    if (pv != NullId && pv <= MaxId) nxt_tbl[pv] = nx;
                    else head_id = nx;
                    if (nx != NullId && nx <= MaxId) prv_tbl[nx] = pv;
                    due(anchor, STS_OK, 1'b1, 1'b0);
                end
            end
            default: begin
                cur = head_id;
                cnt = 0;
                if (cur == NullId || cur > MaxId) begin
                    due(NullId, STS_OK, 1'b1, 1'b1);
                end else begin
                    while (cur != NullId && cur <= MaxId && cnt < MaxNodes) begin
                        nx = nxt_tbl[cur];
                        cnt++;
                        due(cur, STS_OK, !(nx != NullId && nx <= MaxId && cnt < MaxNodes),
                            1'b0);
                        cur = nx;
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_result();
        t_result want;
        if (due_q.size() == 0) begin
            $error("result beat with none due: node_id %0d", i_res_data[6:0]);
            errors++;
            return;
        end
        want = due_q.pop_front();
        if (i_res_data[6:0] !== want.node) begin
            $error("node_id: expected %0d, got %0d", want.node, i_res_data[6:0]);
            errors++;
        end
        if (i_res_data[8:7] !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, i_res_data[8:7]);
            errors++;
        end
        if (i_res_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, i_res_last);
            errors++;
        end
        if (i_res_user !== want.empty) begin
            $error("list_empty: expected %0d, got %0d", want.empty, i_res_user);
            errors++;
        end
    endfunction

    // results leave before a command in the same cycle can add new ones
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_list();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_cmd_valid && i_cmd_ready) apply_cmd(t_cmd'(i_cmd_user), i_cmd_data[IdW-1:0]);
        end
        pending <= due_q.size();
    end

endmodule

// ===== test/indexed_doubly_linked_list_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_test
// Drives list commands into the indexed linked list: a directed opening over
// head, tail and middle inserts and removes and absent ids, then random
// commands mostly on live ids, then a fill to a full table and a drain to an
// empty list. Both streams idle at random and the result side holds off once
// for a long stretch. Checking is done by the checker beside the block.
// ----------------------------------------------------------------------------
module indexed_doubly_linked_list_test;
    import idll_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // ref_id[6:0], zero [7]
    logic [1:0]  s_axis_tuser;    // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // node_id[6:0], status[8:7], zero [15:9]
    logic        m_axis_tlast;    // is_last
    logic        m_axis_tuser;    // list_empty
    int          errors;
    int          outstanding;

    int alive_q[$];
    int gone_q[$];
    int next_id = 2;
    bit steady  = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    indexed_doubly_linked_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    indexed_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (s_axis_tvalid),
        .i_cmd_ready   (s_axis_tready),
        .i_cmd_data    (s_axis_tdata),
        .i_cmd_user    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .i_res_last    (m_axis_tlast),
        .i_res_user    (m_axis_tuser),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int find_alive(int id);
        foreach (alive_q[k]) if (alive_q[k] == id) return k;
        return -1;
    endfunction

    function automatic t_id pick_alive();
        if (alive_q.size() == 0) return t_id'($urandom_range(0, 127));
        return t_id'(alive_q[$urandom_range(0, alive_q.size() - 1)]);
    endfunction

    // ids known to be absent: removed, not yet handed out, null or out of range
    function automatic t_id pick_gone();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0 && gone_q.size() > 0) return t_id'(gone_q[$urandom_range(0, gone_q.size() - 1)]);
        if (r == 1 && next_id <= MaxNodes) return t_id'($urandom_range(next_id, MaxNodes));
        if (r == 2) return NullId;
        return t_id'($urandom_range(MaxNodes + 1, 127));
    endfunction

    function automatic void track(t_cmd cmd, t_id anchor);
        int k;
        k = find_alive(anchor);
        if (cmd == CMD_INS_LEFT || cmd == CMD_INS_RIGHT) begin
            if (next_id <= MaxNodes && k >= 0) begin
                alive_q.push_back(next_id);
                next_id++;
            end
        end else if (cmd == CMD_REMOVE && k >= 0) begin
            alive_q.delete(k);
            gone_q.push_back(anchor);
        end
    endfunction

    task automatic issue(t_cmd cmd, t_id anchor);
        int n;
        n = steady ? 0 : pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, anchor};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        track(cmd, anchor);
    endtask

    // result side: random stalls, quiet stretches, and one long hold-off
    initial begin : sink
        int cyc;
        int stall;
        cyc   = 0;
        stall = 0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 1500) stall = 400;
            else if (stall == 0 && (cyc % 3000) >= 500 && $urandom_range(0, 5) == 0)
                stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        int r;
        int k;
        alive_q.push_back(1);
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_READOUT;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // opening: list of one, head, middle and tail changes, absent ids
        issue(CMD_READOUT,   NullId);
        issue(CMD_INS_LEFT,  FirstId);
        issue(CMD_INS_RIGHT, FirstId);
        issue(CMD_INS_RIGHT, t_id'(3));
        issue(CMD_INS_LEFT,  t_id'(3));
        issue(CMD_READOUT,   t_id'(127));
        issue(CMD_INS_LEFT,  NullId);
        issue(CMD_INS_RIGHT, t_id'(127));
        issue(CMD_INS_LEFT,  MaxId);
        issue(CMD_REMOVE,    NullId);
        issue(CMD_REMOVE,    t_id'(127));
        issue(CMD_REMOVE,    MaxId);
        issue(CMD_REMOVE,    t_id'(2));
        issue(CMD_REMOVE,    t_id'(4));
        issue(CMD_REMOVE,    t_id'(5));
        issue(CMD_READOUT,   NullId);
        issue(CMD_REMOVE,    t_id'(2));
        issue(CMD_INS_LEFT,  t_id'(2));
        issue(CMD_INS_LEFT,  t_id'(3));
        issue(CMD_INS_RIGHT, FirstId);
        issue(CMD_READOUT,   NullId);

        for (int i = 0; i < 300; i++) begin
            steady = (i % 80) < 16;
            r = $urandom_range(0, 99);
            if (r < 30)
                issue(t_cmd'($urandom_range(0, 1)), pick_alive());
            else if (r < 48 && alive_q.size() > 2)
                issue(CMD_REMOVE, pick_alive());
            else if (r < 60)
                issue(CMD_READOUT, t_id'($urandom_range(0, 127)));
            else if (r < 70)
                issue(t_cmd'($urandom_range(0, 2)), pick_gone());
            else
                issue(t_cmd'($urandom_range(0, 3)), t_id'($urandom_range(0, 127)));
        end
        steady = 1'b0;

        // fill the table, then drain the list to empty
        while (next_id <= MaxNodes && alive_q.size() > 0)
            issue(t_cmd'($urandom_range(0, 1)), pick_alive());
        issue(CMD_INS_RIGHT, pick_alive());
        issue(CMD_INS_LEFT,  NullId);
        issue(CMD_READOUT,   NullId);
        while (alive_q.size() > 0) begin
            k = $urandom_range(0, alive_q.size() - 1);
            issue(CMD_REMOVE, t_id'(alive_q[k]));
            if ($urandom_range(0, 7) == 0) issue(CMD_READOUT, NullId);
        end
        issue(CMD_READOUT,   NullId);
        issue(CMD_INS_LEFT,  FirstId);
        issue(CMD_REMOVE,    FirstId);
        issue(CMD_READOUT,   NullId);
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/idll_pkg.sv
design/idll_link_mem.sv
design/indexed_doubly_linked_list.sv
test/indexed_list_checker.sv
test/indexed_doubly_linked_list_test.sv
